// ----- hw/rtl/rbq_pkg.sv -----
package rbq_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ID_W   = 6;
  localparam int MSG_W  = 32;
  localparam int CNT_W  = 7;
  localparam int F_W    = 5;
  localparam int SEND_W = 2;

  // received message kinds
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_READY = 1'b1;

  // outgoing broadcast codes
  localparam logic [SEND_W-1:0] SEND_NONE  = 2'd0;
  localparam logic [SEND_W-1:0] SEND_READY = 2'd1;
  localparam logic [SEND_W-1:0] SEND_ECHO  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SELF_ID     = 2'd0;
  localparam logic [1:0] REG_FAULT_BOUND = 2'd1;
  localparam logic [1:0] REG_QUORUM_SIZE = 2'd2;
  localparam logic [1:0] REG_NODE_COUNT  = 2'd3;

  localparam logic [ID_W-1:0]  SELF_ID_RST     = 6'd0;
  localparam logic [F_W-1:0]   FAULT_BOUND_RST = 5'd21;
  localparam logic [CNT_W-1:0] QUORUM_RST      = 7'd43;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST  = 7'd64;

  typedef struct packed {
    logic             msg_kind;
    logic [ID_W-1:0]  sender_id;
    logic [ID_W-1:0]  origin_id;
    logic [MSG_W-1:0] message_id;
  } in_item_t;

  typedef struct packed {
    logic [SEND_W-1:0] send_kind;
    logic [ID_W-1:0]   out_origin_id;
    logic [MSG_W-1:0]  out_message_id;
    logic [CNT_W-1:0]  fanout_count;
    logic              deliver_now;
    logic [CNT_W-1:0]  echo_count;
    logic [CNT_W-1:0]  ready_count;
  } out_item_t;

  // request after range checks, as queued between front and back
  typedef struct packed {
    logic             msg_kind;
    logic             sender_ok;
    logic             origin_ok;
    logic [ID_W-1:0]  sender_id;
    logic [ID_W-1:0]  origin_id;
    logic [MSG_W-1:0] message_id;
  } cls_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  self_id;
    logic [F_W-1:0]   fault_bound;
    logic [CNT_W-1:0] quorum_size;
    logic [CNT_W-1:0] node_count;
  } cfg_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/reliable_broadcast_quorum_step.sv -----
// Quorum step of a reliable broadcast node: each ECHO or READY request updates the
// sender bitmaps of its broadcaster if its origin id is in range, and yields exactly one
// result with the outgoing broadcast (if any), the delivery flag and both sender counts.
// A request passes the back-end steps in order (bitmap RAM read, merge and per-byte count,
// threshold check and write-back); the next is not taken until that write-back is done.
// A two-entry queue on each side lets the input keep taking requests while a result
// waits to be popped. Bitmaps start empty through per-entry valid bits, so there is no
// clearing pass after reset. Configuration is written through the APB-style port; the
// user must write it only while the block is idle, as the block does not enforce this.
module reliable_broadcast_quorum_step #(
  parameter int MAX_NODES = rbq_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rbq_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output rbq_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rbq_pkg::cfg_t cfg_r, cfg_nxt;
  logic          cfg_wr;

  rbq_pkg::cls_item_t fq_wdata, fq_rdata;
  logic               fq_push, fq_full, fq_pop, fq_empty;

  rbq_pkg::out_item_t oq_wdata;
  logic               oq_push, oq_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        rbq_pkg::REG_SELF_ID:     cfg_nxt.self_id     = pwdata[rbq_pkg::ID_W-1:0];
        rbq_pkg::REG_FAULT_BOUND: cfg_nxt.fault_bound = pwdata[rbq_pkg::F_W-1:0];
        rbq_pkg::REG_QUORUM_SIZE: cfg_nxt.quorum_size = pwdata[rbq_pkg::CNT_W-1:0];
        rbq_pkg::REG_NODE_COUNT:  cfg_nxt.node_count  = pwdata[rbq_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rbq_pkg::REG_SELF_ID:     prdata = 32'(cfg_r.self_id);
      rbq_pkg::REG_FAULT_BOUND: prdata = 32'(cfg_r.fault_bound);
      rbq_pkg::REG_QUORUM_SIZE: prdata = 32'(cfg_r.quorum_size);
      rbq_pkg::REG_NODE_COUNT:  prdata = 32'(cfg_r.node_count);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_id     <= rbq_pkg::SELF_ID_RST;
      cfg_r.fault_bound <= rbq_pkg::FAULT_BOUND_RST;
      cfg_r.quorum_size <= rbq_pkg::QUORUM_RST;
      cfg_r.node_count  <= rbq_pkg::NODE_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbq_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .push   (push),
    .in_data(in_data),
    .full   (full),
    .q_push (fq_push),
    .q_item (fq_wdata),
    .q_full (fq_full)
  );

  rbq_fifo #(
    .WIDTH($bits(rbq_pkg::cls_item_t)),
    .DEPTH(rbq_pkg::QUEUE_DEPTH)
  ) u_req_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .wdata(fq_wdata),
    .full (fq_full),
    .pop  (fq_pop),
    .rdata(fq_rdata),
    .empty(fq_empty)
  );

  rbq_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(fq_empty),
    .q_item (fq_rdata),
    .q_pop  (fq_pop),
    .o_full (oq_full),
    .o_push (oq_push),
    .o_item (oq_wdata)
  );

  rbq_fifo #(
    .WIDTH($bits(rbq_pkg::out_item_t)),
    .DEPTH(rbq_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (oq_push),
    .wdata(oq_wdata),
    .full (oq_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule

// ----- hw/rtl/rbq_ram.sv -----
module rbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/rbq_fifo.sv -----
module rbq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/rbq_front.sv -----
module rbq_front #(
  parameter int MAX_NODES = rbq_pkg::MAX_NODES_DEF
) (
  input  logic               push,
  input  rbq_pkg::in_item_t  in_data,
  output logic               full,
  output logic               q_push,
  output rbq_pkg::cls_item_t q_item,
  input  logic               q_full
);

  localparam logic [rbq_pkg::ID_W:0] NODES_LIM = (rbq_pkg::ID_W + 1)'(MAX_NODES);

  assign full   = q_full;
  assign q_push = push && !q_full;

  // ids past the node range take no bitmap slot
  always_comb begin
    q_item.msg_kind   = in_data.msg_kind;
    q_item.sender_ok  = ({1'b0, in_data.sender_id} < NODES_LIM);
    q_item.origin_ok  = ({1'b0, in_data.origin_id} < NODES_LIM);
    q_item.sender_id  = in_data.sender_id;
    q_item.origin_id  = in_data.origin_id;
    q_item.message_id = in_data.message_id;
  end

endmodule

// ----- hw/rtl/rbq_back.sv -----
module rbq_back #(
  parameter int MAX_NODES = rbq_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbq_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  rbq_pkg::cls_item_t q_item,
  output logic               q_pop,
  input  logic               o_full,
  output logic               o_push,
  output rbq_pkg::out_item_t o_item
);

  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int NG     = (MAX_NODES + 7) / 8;
  localparam int PW     = NG * 8;
  localparam int CW     = rbq_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MRG  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  rbq_pkg::cls_item_t item_r, item_nxt;
  logic [MAX_NODES-1:0] valid_r, valid_nxt;
  logic delivered_r, delivered_nxt;
  logic ready_sent_r, ready_sent_nxt;
  logic echo_sent_r, echo_sent_nxt;

  logic                   ram_re, ram_we;
  logic [2*MAX_NODES-1:0] ram_rdata, ram_wdata;
  logic [ADDR_W-1:0]      addr;

  logic [MAX_NODES-1:0] self_mask, send_mask;
  logic [MAX_NODES-1:0] old_echo, old_ready, echo_m, base_m;
  logic [PW-1:0]        echo_p, base_p;

  logic [MAX_NODES-1:0] echo_r, base_r;
  logic [NG-1:0][3:0]   ecnt_r, rcnt_r;
  logic                 self_add_r;

  logic [CW-1:0] ec, rb, rc, f1, f2;
  logic          quorum_met, self_ready, dlv, is_ready;
  logic [MAX_NODES-1:0] ready_fin;
  logic [rbq_pkg::SEND_W-1:0] send;

  assign addr = item_r.origin_id[ADDR_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      self_mask[i] = (cfg.self_id == rbq_pkg::ID_W'(i));
      send_mask[i] = item_r.sender_ok && (item_r.sender_id == rbq_pkg::ID_W'(i));
    end
  end

  rbq_ram #(
    .WIDTH(2 * MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_sets (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(q_item.origin_id[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // merge stage: entries never written read as empty bitmaps
  always_comb begin
    old_echo  = valid_r[addr] ? ram_rdata[2*MAX_NODES-1:MAX_NODES] : '0;
    old_ready = valid_r[addr] ? ram_rdata[MAX_NODES-1:0] : '0;
    if (item_r.msg_kind == rbq_pkg::KIND_ECHO) begin
      echo_m = old_echo | send_mask | self_mask;
      base_m = old_ready;
    end else begin
      echo_m = old_echo;
      base_m = old_ready | send_mask;
    end
    echo_p = PW'(echo_m);
    base_p = PW'(base_m);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MRG) begin
      echo_r     <= echo_m;
      base_r     <= base_m;
      self_add_r <= (|self_mask) && !(|(self_mask & base_m));
      for (int g = 0; g < NG; g++) begin
        ecnt_r[g] <= rbq_pkg::popcount8(echo_p[g*8 +: 8]);
        rcnt_r[g] <= rbq_pkg::popcount8(base_p[g*8 +: 8]);
      end
    end
  end

  // finish stage: thresholds and the outgoing broadcast
  always_comb begin
    ec = '0;
    rb = '0;
    for (int g = 0; g < NG; g++) begin
      ec = ec + CW'(ecnt_r[g]);
      rb = rb + CW'(rcnt_r[g]);
    end
    f1         = CW'(cfg.fault_bound);
    f2         = {1'b0, cfg.fault_bound, 1'b0};
    quorum_met = (ec >= cfg.quorum_size);
    self_ready = (item_r.msg_kind == rbq_pkg::KIND_READY) ? (rb > f1) : quorum_met;
    rc         = rb + CW'(self_ready && self_add_r);
    ready_fin  = self_ready ? (base_r | self_mask) : base_r;
    dlv        = (rc > f2) && !delivered_r &&
                 ((item_r.msg_kind == rbq_pkg::KIND_READY) || quorum_met);
    is_ready   = (rc > f1) || quorum_met;
    if (!ready_sent_r && is_ready) begin
      send = rbq_pkg::SEND_READY;
    end else if (!echo_sent_r) begin
      send = rbq_pkg::SEND_ECHO;
    end else begin
      send = rbq_pkg::SEND_NONE;
    end
    ram_wdata = {echo_r, ready_fin};
  end

  always_comb begin
    o_item = '0;
    if (item_r.origin_ok) begin
      o_item.send_kind   = send;
      o_item.deliver_now = dlv;
      o_item.echo_count  = ec;
      o_item.ready_count = rc;
      if (send != rbq_pkg::SEND_NONE) begin
        o_item.out_origin_id  = item_r.origin_id;
        o_item.out_message_id = item_r.message_id;
        o_item.fanout_count   = cfg.node_count;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    valid_nxt      = valid_r;
    delivered_nxt  = delivered_r;
    ready_sent_nxt = ready_sent_r;
    echo_sent_nxt  = echo_sent_r;
    q_pop          = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    o_push         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_re    = q_item.origin_ok;
          item_nxt  = q_item;
          state_nxt = ST_MRG;
        end
      end
      ST_MRG: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!o_full) begin
          o_push = 1'b1;
          if (item_r.origin_ok) begin
            ram_we          = 1'b1;
            valid_nxt[addr] = 1'b1;
            if (dlv) begin
              delivered_nxt = 1'b1;
            end
            if (send == rbq_pkg::SEND_READY) begin
              ready_sent_nxt = 1'b1;
            end
            if (send == rbq_pkg::SEND_ECHO) begin
              echo_sent_nxt = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      delivered_r  <= 1'b0;
      ready_sent_r <= 1'b0;
      echo_sent_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      delivered_r  <= delivered_nxt;
      ready_sent_r <= ready_sent_nxt;
      echo_sent_r  <= echo_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ----- dv/quorum_step_checker.sv -----
`timescale 1ns / 100ps

module quorum_step_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  rbq_pkg::in_item_t  in_data,
  input  logic               empty,
  input  logic               pop,
  input  rbq_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 outstanding,
  output int                 checked,
  output int                 deliveries
);

  // sender bitmaps per broadcaster
  bit [63:0] echo_seen  [64];
  bit [63:0] ready_seen [64];
  bit        delivered;
  bit        ready_bcast_done;
  bit        echo_bcast_done;

  bit [rbq_pkg::ID_W-1:0]  self_node;
  bit [rbq_pkg::F_W-1:0]   f_bound;
  bit [rbq_pkg::CNT_W-1:0] quorum;
  bit [rbq_pkg::CNT_W-1:0] fanout;

  int                 accepted;
  rbq_pkg::out_item_t pending_results [$];

  assign outstanding = accepted - checked;

  function automatic rbq_pkg::out_item_t predict_quorum_step(rbq_pkg::in_item_t m);
    rbq_pkg::out_item_t r;
    bit [63:0] from_bit;
    bit [63:0] own_bit;
    int        ec;
    int        rc;
    bit        now_ready;
    r = '0;
    from_bit = 64'd1 << m.sender_id;
    own_bit  = 64'd1 << self_node;
    if (m.msg_kind == rbq_pkg::KIND_ECHO) begin
      echo_seen[m.origin_id] |= from_bit | own_bit;
      if ($countones(echo_seen[m.origin_id]) >= int'(quorum)) begin
        ready_seen[m.origin_id] |= own_bit;
        if ($countones(ready_seen[m.origin_id]) > 2 * int'(f_bound) && !delivered) begin
          delivered     = 1'b1;
          r.deliver_now = 1'b1;
        end
      end
    end else begin
      ready_seen[m.origin_id] |= from_bit;
      // enough ready peers: this node joins in
      if ($countones(ready_seen[m.origin_id]) > int'(f_bound)) begin
        ready_seen[m.origin_id] |= own_bit;
      end
      if ($countones(ready_seen[m.origin_id]) > 2 * int'(f_bound) && !delivered) begin
        delivered     = 1'b1;
        r.deliver_now = 1'b1;
      end
    end
    ec = $countones(echo_seen[m.origin_id]);
    rc = $countones(ready_seen[m.origin_id]);
    now_ready = (rc > int'(f_bound)) || (ec >= int'(quorum));
    if (!ready_bcast_done && now_ready) begin
      ready_bcast_done = 1'b1;
      r.send_kind      = rbq_pkg::SEND_READY;
    end else if (!echo_bcast_done) begin
      echo_bcast_done = 1'b1;
      r.send_kind     = rbq_pkg::SEND_ECHO;
    end
    if (r.send_kind != rbq_pkg::SEND_NONE) begin
      r.out_origin_id  = m.origin_id;
      r.out_message_id = m.message_id;
      r.fanout_count   = fanout;
    end
    r.echo_count  = ec[rbq_pkg::CNT_W-1:0];
    r.ready_count = rc[rbq_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string fname, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: result %0d field %s expected %0h actual %0h",
               $time, checked, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rbq_pkg::out_item_t want;
    if (!rst_n) begin
      for (int o = 0; o < 64; o++) begin
        echo_seen[o]  = '0;
        ready_seen[o] = '0;
      end
      delivered        = 1'b0;
      ready_bcast_done = 1'b0;
      echo_bcast_done  = 1'b0;
      self_node        = rbq_pkg::SELF_ID_RST;
      f_bound          = rbq_pkg::FAULT_BOUND_RST;
      quorum           = rbq_pkg::QUORUM_RST;
      fanout           = rbq_pkg::NODE_COUNT_RST;
      pending_results.delete();
      accepted   <= 0;
      checked    <= 0;
      deliveries <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          rbq_pkg::REG_SELF_ID:     self_node = pwdata[rbq_pkg::ID_W-1:0];
          rbq_pkg::REG_FAULT_BOUND: f_bound   = pwdata[rbq_pkg::F_W-1:0];
          rbq_pkg::REG_QUORUM_SIZE: quorum    = pwdata[rbq_pkg::CNT_W-1:0];
          rbq_pkg::REG_NODE_COUNT:  fanout    = pwdata[rbq_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      // results first, so a request taken in the same cycle is not matched
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %0h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("send_kind", 64'(want.send_kind), 64'(out_data.send_kind));
          check_field("out_origin_id", 64'(want.out_origin_id),
                      64'(out_data.out_origin_id));
          check_field("out_message_id", 64'(want.out_message_id),
                      64'(out_data.out_message_id));
          check_field("fanout_count", 64'(want.fanout_count),
                      64'(out_data.fanout_count));
          check_field("deliver_now", 64'(want.deliver_now), 64'(out_data.deliver_now));
          check_field("echo_count", 64'(want.echo_count), 64'(out_data.echo_count));
          check_field("ready_count", 64'(want.ready_count), 64'(out_data.ready_count));
          checked <= checked + 1;
          if (out_data.deliver_now) begin
            deliveries <= deliveries + 1;
          end
        end
      end
      if (push && !full) begin
        pending_results.insert(pending_results.size(), predict_quorum_step(in_data));
        accepted <= accepted + 1;
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;

  typedef enum int {PACE_SEND30_RECV50, PACE_SEND50_RECV30, PACE_FREE} pace_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               push    = 1'b0;
  rbq_pkg::in_item_t  in_data = '0;
  logic               pop     = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [3:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               full;
  logic               empty;
  rbq_pkg::out_item_t out_data;
  logic [31:0]        prdata;
  logic               pready;

  int    chk_errors;
  int    chk_outstanding;
  int    chk_checked;
  int    chk_deliveries;
  int    cycles = 0;
  int    n_sent = 0;
  int    full_stalls = 0;
  pace_t idle_mode = PACE_SEND30_RECV50;
  bit    backpressure_done = 1'b0;
  logic [rbq_pkg::ID_W-1:0] hot_origin [4];

  reliable_broadcast_quorum_step i_dut (
    .clk, .rst_n, .push, .full, .in_data, .empty, .pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  quorum_step_checker i_checker (
    .clk, .rst_n, .push, .full, .in_data, .empty, .pop, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors(chk_errors), .outstanding(chk_outstanding),
    .checked(chk_checked), .deliveries(chk_deliveries)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, chk_outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int sender_idle_pct();
    case (idle_mode)
      PACE_SEND30_RECV50: return 30;
      PACE_SEND50_RECV30: return 50;
      default:            return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      PACE_SEND30_RECV50: return 50;
      PACE_SEND50_RECV30: return 30;
      default:            return 0;
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off once the free-running phase starts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_mode == PACE_FREE && !backpressure_done) begin
        backpressure_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct());
      end
    end
  end

  function automatic rbq_pkg::in_item_t req(logic kind, int sender, int origin,
                                            logic [31:0] msg);
    rbq_pkg::in_item_t m;
    m.msg_kind   = kind;
    m.sender_id  = sender[rbq_pkg::ID_W-1:0];
    m.origin_id  = origin[rbq_pkg::ID_W-1:0];
    m.message_id = msg;
    return m;
  endfunction

  // mostly traffic on a few broadcasters so their counts climb through the thresholds
  function automatic rbq_pkg::in_item_t random_request();
    rbq_pkg::in_item_t m;
    m.msg_kind   = 1'($urandom_range(0, 1));
    m.sender_id  = rbq_pkg::ID_W'($urandom_range(0, 63));
    m.message_id = $urandom();
    if ($urandom_range(0, 99) < 80) begin
      m.origin_id = hot_origin[$urandom_range(0, 3)];
    end else begin
      m.origin_id = rbq_pkg::ID_W'($urandom_range(0, 63));
    end
    return m;
  endfunction

  task automatic push_item(input rbq_pkg::in_item_t m);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= m;
    do begin
      @(posedge clk);
      if (full) begin
        full_stalls++;
      end
    end while (full);
    n_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    do @(posedge clk); while (chk_outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input pace_t pace, input int self_v, input int f_v,
                           input int q_v, input int n_v, input int count);
    drain_results();
    idle_mode = pace;
    write_reg(rbq_pkg::REG_SELF_ID, self_v);
    write_reg(rbq_pkg::REG_FAULT_BOUND, f_v);
    write_reg(rbq_pkg::REG_QUORUM_SIZE, q_v);
    write_reg(rbq_pkg::REG_NODE_COUNT, n_v);
    for (int h = 0; h < 4; h++) begin
      hot_origin[h] = rbq_pkg::ID_W'($urandom_range(0, 63));
    end
    for (int i = 0; i < count; i++) begin
      push_item(random_request());
    end
    push <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quorum of one makes the very first request ready, so the ready broadcast
    // goes out first and the echo broadcast follows on the next request
    write_reg(rbq_pkg::REG_QUORUM_SIZE, 1);
    push_item(req(rbq_pkg::KIND_ECHO, 0, 0, 32'h0000_0000));
    push_item(req(rbq_pkg::KIND_READY, 63, 63, 32'hFFFF_FFFF));
    push_item(req(rbq_pkg::KIND_ECHO, 63, 0, 32'hA5A5_A5A5));
    push_item(req(rbq_pkg::KIND_ECHO, 63, 0, 32'h5A5A_5A5A));
    push_item(req(rbq_pkg::KIND_READY, 0, 0, 32'h0000_FFFF));
    push_item(req(rbq_pkg::KIND_READY, 0, 0, 32'hFFFF_0000));
    push_item(req(rbq_pkg::KIND_ECHO, 17, 5, 32'h1234_5678));
    push_item(req(rbq_pkg::KIND_READY, 1, 63, 32'h8000_0001));
    push_item(req(rbq_pkg::KIND_READY, 2, 63, 32'h7FFF_FFFE));
    push_item(req(rbq_pkg::KIND_ECHO, 63, 63, 32'hDEAD_BEEF));
    push_item(req(rbq_pkg::KIND_READY, 40, 40, 32'h0000_0001));
    push_item(req(rbq_pkg::KIND_ECHO, 40, 40, 32'h0000_0000));
    push <= 1'b0;

    run_phase(PACE_SEND30_RECV50, 63, 0, 64, 1, 300);
    run_phase(PACE_SEND30_RECV50, $urandom_range(0, 63), 10, 20, 32, 250);
    // values past the nominal ranges: f of 31, quorum of 0, fanout of 127
    run_phase(PACE_SEND50_RECV30, $urandom_range(0, 63), 31, 0, 127, 250);
    run_phase(PACE_SEND50_RECV30, $urandom_range(0, 63), $urandom_range(0, 21),
              $urandom_range(1, 64), $urandom_range(1, 64), 250);
    run_phase(PACE_FREE, 33, 21, 43, 64, 250);
    run_phase(PACE_FREE, $urandom_range(0, 63), 1, 127, 0, 250);

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d requests over 7 register settings, %0d results checked, %0d delivery",
             n_sent, chk_checked, chk_deliveries);
    $display("input stalled by full for %0d cycles, one receiver hold-off of %0d cycles",
             full_stalls, HOLD_CYCLES);
    if (chk_errors == 0 && chk_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", chk_errors, chk_outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- reliable_broadcast_quorum_step.f -----
hw/rtl/rbq_pkg.sv
hw/rtl/rbq_ram.sv
hw/rtl/rbq_fifo.sv
hw/rtl/rbq_front.sv
hw/rtl/rbq_back.sv
hw/rtl/reliable_broadcast_quorum_step.sv
dv/quorum_step_checker.sv
dv/tb_top.sv
